// File: hw/rtl/dnlp_pkg.sv
// Package for the node line parser: result kinds, error codes, parse phases and
// the record type passed from the front classifier to the back emitter.
// Used by every module in hw/rtl; no dependencies.
package dnlp_pkg;

   localparam logic [2:0] KIND_OP    = 3'd0;
   localparam logic [2:0] KIND_ARG   = 3'd1;
   localparam logic [2:0] KIND_CMT   = 3'd2;
   localparam logic [2:0] KIND_JUNK  = 3'd3;
   localparam logic [2:0] KIND_NODE  = 3'd4;
   localparam logic [2:0] KIND_JLINE = 3'd5;
   localparam logic [2:0] KIND_ERR   = 3'd6;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_TOOLARGE = 3'd1;
   localparam logic [2:0] ERR_BADNEG   = 3'd2;
   localparam logic [2:0] ERR_MISSNUM  = 3'd3;
   localparam logic [2:0] ERR_MISSOP   = 3'd4;
   localparam logic [2:0] ERR_QUOTE    = 3'd5;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam int unsigned RADIX   = 10;

   typedef enum logic [3:0] {
      PH_START, PH_JUNK, PH_NUM_FIRST, PH_NUM_DIGITS, PH_NEG_ONE, PH_NEG_AFTER,
      PH_OP_FIRST, PH_OP_MORE, PH_AFTER_OP, PH_ARGS, PH_AFTER_ARGS,
      PH_COMMENT, PH_IGNORE
   } phase_type;

   // Token from the front part: a kind and character, or a record / error cue.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] text_char;
      logic [2:0] error_code;
      logic [1:0] error_field;
   } token_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

// File: hw/rtl/dnlp_front.sv
// Front part: line classifier and number accumulator, one character per cycle
// unless stalled. Uses dnlp_pkg; produces tokens, held numbers and chain number.
module dnlp_front #(
   parameter int NUMBER_WIDTH      = 32,
   parameter int CHAIN_COUNT_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [7:0]                   in_ch,
   input  logic                         in_line_end,
   output logic                         in_stall,
   output logic                         tok_valid,
   output dnlp_pkg::token_type          tok,
   output logic [CHAIN_COUNT_WIDTH-1:0] tok_chain,
   output logic [4*NUMBER_WIDTH-1:0]    tok_nums,
   input  logic                         tok_stall
);
   localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = {1'b0, {(NUMBER_WIDTH-1){1'b1}}};
   localparam logic [NUMBER_WIDTH-1:0] NUM_TEN = NUMBER_WIDTH'(dnlp_pkg::RADIX);

   dnlp_pkg::phase_type          phase_ff, phase_in;
   logic                         block_ff, block_in;
   logic                         halted_ff, halted_in;
   logic [1:0]                   field_ff, field_in;
   logic [CHAIN_COUNT_WIDTH-1:0] chain_ff, chain_in;
   logic [NUMBER_WIDTH-1:0]      acc_ff, acc_in;
   logic [NUMBER_WIDTH-1:0]      held_ff [4];
   logic [NUMBER_WIDTH-1:0]      store_val;
   logic                         store_en;
   logic                         emit;
   dnlp_pkg::token_type          t;
   logic [NUMBER_WIDTH-1:0]      digit;
   logic [NUMBER_WIDTH+3:0]      times_ten;
   logic                         fire;

   assign in_stall = tok_stall;
   assign fire     = in_valid && !tok_stall && !halted_ff;
   assign digit    = NUMBER_WIDTH'(in_ch - 8'h30);
   assign times_ten = (NUMBER_WIDTH+4)'(acc_ff) * (NUMBER_WIDTH+4)'(NUM_TEN)
                    + (NUMBER_WIDTH+4)'(digit);

   // Two passes at most: a phase that falls through hands the character on.
   always_comb begin
      dnlp_pkg::phase_type ph;
      logic again;
      ph        = phase_ff;
      phase_in  = phase_ff;
      block_in  = block_ff;
      halted_in = halted_ff;
      field_in  = field_ff;
      chain_in  = chain_ff;
      acc_in    = acc_ff;
      store_en  = 1'b0;
      store_val = acc_ff;
      emit      = 1'b0;
      t         = '{kind: dnlp_pkg::KIND_OP, text_char: in_ch,
                    error_code: dnlp_pkg::ERR_NONE, error_field: 2'd0};
      again     = 1'b1;
      for (int pass = 0; pass < 3; pass++) begin
         if (again) begin
            again = 1'b0;
            case (ph)
               dnlp_pkg::PH_START: begin
                  if (!in_line_end && in_ch == dnlp_pkg::CH_HASH) begin
                     block_in = 1'b1;
                     field_in = 2'd0;
                     ph = dnlp_pkg::PH_NUM_FIRST;
                  end else begin
                     if (block_ff) begin
                        block_in = 1'b0;
                        if (chain_ff != {CHAIN_COUNT_WIDTH{1'b1}})
                           chain_in = chain_ff + 1'b1;
                     end
                     ph = dnlp_pkg::PH_JUNK;
                     again = 1'b1;
                  end
               end
               dnlp_pkg::PH_JUNK: begin
                  emit = 1'b1;
                  if (in_line_end) begin
                     t.kind = dnlp_pkg::KIND_JLINE;
                     t.text_char = 8'd0;
                     ph = dnlp_pkg::PH_START;
                  end else begin
                     t.kind = dnlp_pkg::KIND_JUNK;
                  end
               end
               dnlp_pkg::PH_NUM_FIRST: begin
                  if (!in_line_end && field_in != 2'd0 && dnlp_pkg::is_blank(in_ch)) begin
                  end else if (!in_line_end && dnlp_pkg::is_digit(in_ch)) begin
                     acc_in = digit;
                     ph = dnlp_pkg::PH_NUM_DIGITS;
                  end else if (!in_line_end && in_ch == dnlp_pkg::CH_MINUS) begin
                     ph = dnlp_pkg::PH_NEG_ONE;
                  end else begin
                     emit = 1'b1; halted_in = 1'b1;
                     t = '{dnlp_pkg::KIND_ERR, 8'd0, dnlp_pkg::ERR_MISSNUM, field_in};
                  end
               end
               dnlp_pkg::PH_NUM_DIGITS: begin
                  if (!in_line_end && dnlp_pkg::is_digit(in_ch)) begin
                     if (times_ten > (NUMBER_WIDTH+4)'(NUM_MAX)) begin
                        emit = 1'b1; halted_in = 1'b1;
                        t = '{dnlp_pkg::KIND_ERR, 8'd0, dnlp_pkg::ERR_TOOLARGE, field_ff};
                     end else begin
                        acc_in = times_ten[NUMBER_WIDTH-1:0];
                     end
                  end else begin
                     store_en = 1'b1; store_val = acc_ff;
                     if (field_ff != 2'd3) begin
                        field_in = field_ff + 2'd1;
                        ph = dnlp_pkg::PH_NUM_FIRST;
                     end else begin
                        ph = dnlp_pkg::PH_OP_FIRST;
                     end
                     again = 1'b1;
                  end
               end
               dnlp_pkg::PH_NEG_ONE: begin
                  if (!in_line_end && in_ch == dnlp_pkg::CH_ONE) begin
                     ph = dnlp_pkg::PH_NEG_AFTER;
                  end else begin
                     emit = 1'b1; halted_in = 1'b1;
                     t = '{dnlp_pkg::KIND_ERR, 8'd0, dnlp_pkg::ERR_BADNEG, field_ff};
                  end
               end
               dnlp_pkg::PH_NEG_AFTER: begin
                  if (!in_line_end && dnlp_pkg::is_digit(in_ch)) begin
                     emit = 1'b1; halted_in = 1'b1;
                     t = '{dnlp_pkg::KIND_ERR, 8'd0, dnlp_pkg::ERR_BADNEG, field_ff};
                  end else begin
                     store_en = 1'b1; store_val = '1;
                     if (field_ff != 2'd3) begin
                        field_in = field_ff + 2'd1;
                        ph = dnlp_pkg::PH_NUM_FIRST;
                     end else begin
                        ph = dnlp_pkg::PH_OP_FIRST;
                     end
                     again = 1'b1;
                  end
               end
               dnlp_pkg::PH_OP_FIRST: begin
                  if (!in_line_end && dnlp_pkg::is_blank(in_ch)) begin
                  end else if (!in_line_end && dnlp_pkg::is_alnum(in_ch)) begin
                     emit = 1'b1; t.kind = dnlp_pkg::KIND_OP;
                     ph = dnlp_pkg::PH_OP_MORE;
                  end else begin
                     emit = 1'b1; halted_in = 1'b1;
                     t = '{dnlp_pkg::KIND_ERR, 8'd0, dnlp_pkg::ERR_MISSOP, 2'd0};
                  end
               end
               dnlp_pkg::PH_OP_MORE: begin
                  if (!in_line_end && dnlp_pkg::is_alnum(in_ch)) begin
                     emit = 1'b1; t.kind = dnlp_pkg::KIND_OP;
                  end else begin
                     ph = dnlp_pkg::PH_AFTER_OP;
                     again = 1'b1;
                  end
               end
               dnlp_pkg::PH_AFTER_OP, dnlp_pkg::PH_AFTER_ARGS: begin
                  if (in_line_end) begin
                     emit = 1'b1; t.kind = dnlp_pkg::KIND_NODE; t.text_char = 8'd0;
                     ph = dnlp_pkg::PH_START;
                  end else if (dnlp_pkg::is_blank(in_ch)) begin
                  end else if (ph == dnlp_pkg::PH_AFTER_OP && in_ch == dnlp_pkg::CH_QUOTE) begin
                     emit = 1'b1; t.kind = dnlp_pkg::KIND_ARG;
                     ph = dnlp_pkg::PH_ARGS;
                  end else if (in_ch == dnlp_pkg::CH_SEMI) begin
                     emit = 1'b1; t.kind = dnlp_pkg::KIND_CMT;
                     ph = dnlp_pkg::PH_COMMENT;
                  end else begin
                     ph = dnlp_pkg::PH_IGNORE;
                  end
               end
               dnlp_pkg::PH_ARGS: begin
                  emit = 1'b1;
                  if (in_line_end) begin
                     halted_in = 1'b1;
                     t = '{dnlp_pkg::KIND_ERR, 8'd0, dnlp_pkg::ERR_QUOTE, 2'd0};
                  end else begin
                     t.kind = dnlp_pkg::KIND_ARG;
                     if (in_ch == dnlp_pkg::CH_QUOTE) ph = dnlp_pkg::PH_AFTER_ARGS;
                  end
               end
               dnlp_pkg::PH_COMMENT, dnlp_pkg::PH_IGNORE: begin
                  if (in_line_end) begin
                     emit = 1'b1; t.kind = dnlp_pkg::KIND_NODE; t.text_char = 8'd0;
                     ph = dnlp_pkg::PH_START;
                  end else if (ph == dnlp_pkg::PH_COMMENT) begin
                     emit = 1'b1; t.kind = dnlp_pkg::KIND_CMT;
                  end
               end
               default: begin
                  ph = dnlp_pkg::PH_START;
               end
            endcase
         end
      end
      phase_in = ph;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= dnlp_pkg::PH_START;
         block_ff  <= 1'b0;
         halted_ff <= 1'b0;
         field_ff  <= 2'd0;
         chain_ff  <= '0;
         acc_ff    <= '0;
         tok_valid <= 1'b0;
         for (int i = 0; i < 4; i++) held_ff[i] <= '0;
      end else if (!tok_stall) begin
         tok_valid <= fire && emit;
         if (fire) begin
            phase_ff  <= phase_in;
            block_ff  <= block_in;
            halted_ff <= halted_in;
            field_ff  <= field_in;
            chain_ff  <= chain_in;
            acc_ff    <= acc_in;
            if (store_en) held_ff[field_ff] <= store_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!tok_stall && fire) begin
         tok       <= t;
         tok_chain <= chain_in;
      end
   end

   assign tok_nums = {held_ff[3], held_ff[2], held_ff[1], held_ff[0]};
endmodule

// File: hw/rtl/dnlp_back.sv
// Back part: two-entry skid queue that turns tokens into result transfers.
// Depends on dnlp_pkg; fed by dnlp_front.
module dnlp_back #(
   parameter int NUMBER_WIDTH      = 32,
   parameter int CHAIN_COUNT_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tok_valid,
   input  dnlp_pkg::token_type          tok,
   input  logic [CHAIN_COUNT_WIDTH-1:0] tok_chain,
   input  logic [4*NUMBER_WIDTH-1:0]    tok_nums,
   output logic                         tok_stall,
   output logic                         out_valid,
   output dnlp_pkg::token_type          out_tok,
   output logic [CHAIN_COUNT_WIDTH-1:0] out_chain,
   output logic [4*NUMBER_WIDTH-1:0]    out_nums,
   input  logic                         out_stall
);
   localparam int EW = $bits(dnlp_pkg::token_type) + CHAIN_COUNT_WIDTH + 4*NUMBER_WIDTH;
   logic [EW-1:0] q_ff [2];
   logic          rd_ff, wr_ff;
   logic [1:0]    cnt_ff;
   logic [EW-1:0] entry;
   logic          push, pop;
   logic [NUMBER_WIDTH*4-1:0] nums;

   // Numbers travel only with node records; other kinds carry zeros.
   assign nums  = (tok.kind == dnlp_pkg::KIND_NODE) ? tok_nums : '0;
   assign entry = {tok, tok_chain, nums};
   assign tok_stall = (cnt_ff == 2'd2);
   assign push = tok_valid && !tok_stall;
   assign pop  = out_valid && !out_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign {out_tok, out_chain, out_nums} = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= entry;
   end
endmodule

// File: hw/rtl/dag_node_line_parser_top.sv
// Top level of the node line parser: front classifier, token queue, result port.
// Depends on dnlp_pkg, dnlp_front and dnlp_back.
//
//   channel | ports                               | direction
//   req     | req_valid req_stall req_ch          | in, one character per transfer
//           | req_line_end                        |
//   rsp     | rsp_valid rsp_stall rsp_kind ...    | out, at most one per character
//
// A character is taken every cycle unless req stalls; its result, if any,
// passes the front token register and then the back queue before rsp offers it.
// The rate is set by the combinational front phase logic and number accumulator.
// Reset is synchronous and clears phases, counters and the queue.
// The front stalls only when the two-entry queue in the back part is full; req
// stalls in the same cycle and the front token register holds its transfer.
// After an error the block takes characters and drops them until reset.
module dag_node_line_parser_top #(
   parameter int NUMBER_WIDTH      = 32,
   parameter int CHAIN_COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_ch,
   input  logic                          req_line_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_kind,
   output logic [7:0]                    rsp_text_char,
   output logic [CHAIN_COUNT_WIDTH-1:0]  rsp_chain_index,
   output logic signed [NUMBER_WIDTH-1:0] rsp_node_identity,
   output logic signed [NUMBER_WIDTH-1:0] rsp_left_child,
   output logic signed [NUMBER_WIDTH-1:0] rsp_right_child,
   output logic signed [NUMBER_WIDTH-1:0] rsp_next_node,
   output logic [2:0]                    rsp_error_code,
   output logic [1:0]                    rsp_error_field
);
   logic                         tok_valid, tok_stall;
   dnlp_pkg::token_type          tok, out_tok;
   logic [CHAIN_COUNT_WIDTH-1:0] tok_chain;
   logic [4*NUMBER_WIDTH-1:0]    tok_nums, out_nums;

   dnlp_front #(.NUMBER_WIDTH(NUMBER_WIDTH), .CHAIN_COUNT_WIDTH(CHAIN_COUNT_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ch(req_ch), .in_line_end(req_line_end),
      .in_stall(req_stall),
      .tok_valid, .tok, .tok_chain, .tok_nums, .tok_stall
   );

   dnlp_back #(.NUMBER_WIDTH(NUMBER_WIDTH), .CHAIN_COUNT_WIDTH(CHAIN_COUNT_WIDTH)) u_back (
      .clock, .reset,
      .tok_valid, .tok, .tok_chain, .tok_nums, .tok_stall,
      .out_valid(rsp_valid), .out_tok, .out_chain(rsp_chain_index), .out_nums,
      .out_stall(rsp_stall)
   );

   assign rsp_kind          = out_tok.kind;
   assign rsp_text_char     = out_tok.text_char;
   assign rsp_error_code    = out_tok.error_code;
   assign rsp_error_field   = out_tok.error_field;
   assign rsp_node_identity = out_nums[NUMBER_WIDTH-1:0];
   assign rsp_left_child    = out_nums[2*NUMBER_WIDTH-1:NUMBER_WIDTH];
   assign rsp_right_child   = out_nums[3*NUMBER_WIDTH-1:2*NUMBER_WIDTH];
   assign rsp_next_node     = out_nums[4*NUMBER_WIDTH-1:3*NUMBER_WIDTH];
endmodule

// File: hw/rtl/dnlp_checker.sv
// Port checker for the node line parser, bound to the top level.
// Depends on dnlp_pkg and dag_node_line_parser_top.
module dnlp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_text_char,
   input logic [2:0] rsp_error_code
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result changed");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != dnlp_pkg::KIND_ERR |-> rsp_error_code == dnlp_pkg::ERR_NONE)
      else $error("error code outside an error");
   a_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dnlp_pkg::KIND_NODE || rsp_kind == dnlp_pkg::KIND_JLINE)
      |-> rsp_text_char == 8'd0)
      else $error("record carries a character");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind != 3'd7)
      else $error("undefined kind");
endmodule

bind dag_node_line_parser_top dnlp_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_kind, .rsp_text_char, .rsp_error_code
);
